### design/b58_pkg.sv
// Shared types, constants and arithmetic helpers for the base58 encoder.
package b58_pkg;

  // Radix of the encoding and digit storage geometry.
  localparam int RADIX       = 58;
  localparam int DIGIT_W     = 6;
  localparam int DIGIT_DEPTH = 64;

  // ASCII '1' stands for each leading zero byte.
  localparam logic [7:0] ZERO_CHAR = 8'h31;

  // The alphabet, first character in the top byte.
  localparam logic [8*RADIX-1:0] ALPHABET =
    "123456789ABCDEFGHJKLMNPQRSTUVWXYZabcdefghijkmnopqrstuvwxyz";

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic store;       // write an input byte into the byte store
    logic init;        // begin digit generation for a finished string
    logic pass_begin;  // start one long-division pass
    logic pass_step;   // divide one stored byte
    logic digit_wr;    // record the pass remainder as a digit
    logic emit_begin;  // set up character output
    logic emit_load;   // load one character into the output register
  } b58_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic start_lt_n;  // the number still has nonzero bytes
    logic pass_last;   // the current pass step handles the final byte
    logic emit_last;   // the next character is the final one
    logic out_free;    // the output register can take a character
  } b58_sts_t;

  // Map a digit to its ASCII character.
  function automatic logic [7:0] b58_char(input logic [DIGIT_W-1:0] d);
    logic [7:0] c;
    c = 8'h00;
    for (int i = 0; i < RADIX; i++) begin
      if (d == DIGIT_W'(i)) begin
        c = ALPHABET[8*(RADIX-1-i) +: 8];
      end
    end
    return c;
  endfunction

  // One long-division step: (rem * 256 + b) / 58, returned as {quotient, remainder}.
  // rem * 256 is split through a constant table; the rest needs at most five compares.
  function automatic logic [7+DIGIT_W:0] b58_div_step(input logic [DIGIT_W-1:0] rem,
                                                        input logic [7:0]         b);
    logic [7:0]         q1;
    logic [DIGIT_W-1:0] r1;
    logic [8:0]         s;
    logic [8:0]         r;
    logic [2:0]         k;
    q1 = 8'h00;
    r1 = '0;
    for (int i = 0; i < RADIX; i++) begin
      if (rem == DIGIT_W'(i)) begin
        q1 = 8'((i * 256) / RADIX);
        r1 = DIGIT_W'((i * 256) % RADIX);
      end
    end
    s = {3'b000, r1} + {1'b0, b};
    k = 3'd0;
    r = s;
    for (int j = 1; j <= 5; j++) begin
      if (s >= 9'(j * RADIX)) begin
        k = 3'(j);
        r = s - 9'(j * RADIX);
      end
    end
    return {8'(q1 + {5'b00000, k}), r[DIGIT_W-1:0]};
  endfunction

endpackage

### design/b58_ram.sv
// Generic single-write, single-read RAM with registered read data.
module b58_ram #(
  parameter int W     = 8,
  parameter int DEPTH = 32,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic [AW-1:0] raddr,
  output logic [W-1:0]  rdata
);

  logic [W-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

### design/b58_dp.sv
// Datapath: byte and digit stores, long-division unit, counters and output register.
module b58_dp #(
  parameter int MAX_BYTES = 32,
  parameter int MAX_CHARS = 44
) (
  input  logic              clk,
  input  logic              rst_n,
  input  b58_pkg::b58_cmd_t cmd,
  output b58_pkg::b58_sts_t sts,
  input  logic [7:0]        in_data,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [7:0]        out_tdata,
  output logic              out_tlast
);
  import b58_pkg::*;

  localparam int CW    = $clog2(MAX_BYTES + 1);
  localparam int AW    = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;
  localparam int DAW   = $clog2(DIGIT_DEPTH);
  localparam int SUM_W = $clog2(MAX_BYTES + DIGIT_DEPTH);

  // String bookkeeping.
  logic [CW-1:0]      byte_cnt_r;
  logic [CW-1:0]      zero_cnt_r;
  logic               in_zero_r;
  logic [DAW-1:0]     digit_cnt_r;

  // Division and output sequencing.
  logic [CW-1:0]      start_r;
  logic [CW-1:0]      idx_r;
  logic [DIGIT_W-1:0] rem_r;
  logic               nz_found_r;
  logic [CW-1:0]      nz_idx_r;
  logic [SUM_W-1:0]   char_cnt_r;
  logic [DAW-1:0]     dptr_r;
  logic               out_valid_r;
  logic [7:0]         out_char_r;
  logic               out_last_r;

  // Memory ports.
  logic               bram_we;
  logic [AW-1:0]      bram_waddr;
  logic [7:0]         bram_wdata;
  logic [AW-1:0]      bram_raddr;
  logic [7:0]         bram_rdata;
  logic [DIGIT_W-1:0] dram_rdata;

  logic               not_full;
  logic [CW-1:0]      idx_inc;
  logic [7:0]         step_q;
  logic [DIGIT_W-1:0] step_r;
  logic [SUM_W-1:0]   total_raw;
  logic [SUM_W-1:0]   total;
  logic               emit_zero;

  assign not_full = (byte_cnt_r < CW'(MAX_BYTES));
  assign idx_inc  = CW'(idx_r + 1'b1);
  assign {step_q, step_r} = b58_div_step(rem_r, bram_rdata);

  // Character count, limited to the output length.
  assign total_raw = SUM_W'(zero_cnt_r) + SUM_W'(digit_cnt_r);
  assign total     = (total_raw > SUM_W'(MAX_CHARS)) ? SUM_W'(MAX_CHARS) : total_raw;
  assign emit_zero = (char_cnt_r < SUM_W'(zero_cnt_r));

  // Byte store port selection: input beats in idle, quotients during a pass.
  always_comb begin
    bram_we    = (cmd.store && not_full) || cmd.pass_step;
    bram_waddr = cmd.pass_step ? idx_r[AW-1:0] : byte_cnt_r[AW-1:0];
    bram_wdata = cmd.pass_step ? step_q : in_data;
    bram_raddr = cmd.pass_begin ? start_r[AW-1:0] : idx_inc[AW-1:0];
  end

  b58_ram #(.W(8), .DEPTH(MAX_BYTES)) u_byte_ram (
    .clk   (clk),
    .we    (bram_we),
    .waddr (bram_waddr),
    .wdata (bram_wdata),
    .raddr (bram_raddr),
    .rdata (bram_rdata)
  );

  b58_ram #(.W(DIGIT_W), .DEPTH(DIGIT_DEPTH)) u_digit_ram (
    .clk   (clk),
    .we    (cmd.digit_wr),
    .waddr (digit_cnt_r),
    .wdata (rem_r),
    .raddr (dptr_r),
    .rdata (dram_rdata)
  );

  // Counters and output valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_cnt_r  <= '0;
      zero_cnt_r  <= '0;
      in_zero_r   <= 1'b1;
      digit_cnt_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.store && not_full) begin
        byte_cnt_r <= CW'(byte_cnt_r + 1'b1);
        if (in_zero_r && in_data == 8'h00) begin
          zero_cnt_r <= CW'(zero_cnt_r + 1'b1);
        end else begin
          in_zero_r <= 1'b0;
        end
      end
      if (cmd.init) begin
        digit_cnt_r <= '0;
      end
      if (cmd.digit_wr) begin
        digit_cnt_r <= DAW'(digit_cnt_r + 1'b1);
      end
      if (cmd.emit_load) begin
        out_valid_r <= 1'b1;
        if (sts.emit_last) begin
          byte_cnt_r <= '0;
          zero_cnt_r <= '0;
          in_zero_r  <= 1'b1;
        end
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Division pass registers and character output registers.
  always_ff @(posedge clk) begin
    if (cmd.init) begin
      start_r <= zero_cnt_r;
    end
    if (cmd.pass_begin) begin
      idx_r      <= start_r;
      rem_r      <= '0;
      nz_found_r <= 1'b0;
      nz_idx_r   <= byte_cnt_r;
    end
    if (cmd.pass_step) begin
      idx_r <= idx_inc;
      rem_r <= step_r;
      if (step_q != 8'h00 && !nz_found_r) begin
        nz_found_r <= 1'b1;
        nz_idx_r   <= idx_r;
      end
    end
    // The next pass begins at the first nonzero quotient byte.
    if (cmd.digit_wr) begin
      start_r <= nz_idx_r;
    end
    if (cmd.emit_begin) begin
      char_cnt_r <= '0;
      dptr_r     <= DAW'(digit_cnt_r - 1'b1);
    end
    if (cmd.emit_load) begin
      out_char_r <= emit_zero ? ZERO_CHAR : b58_char(dram_rdata);
      out_last_r <= sts.emit_last;
      char_cnt_r <= SUM_W'(char_cnt_r + 1'b1);
      if (!emit_zero) begin
        dptr_r <= DAW'(dptr_r - 1'b1);
      end
    end
  end

  // Status toward the controller.
  always_comb begin
    sts.start_lt_n = (start_r < byte_cnt_r);
    sts.pass_last  = (idx_inc == byte_cnt_r);
    sts.emit_last  = (SUM_W'(char_cnt_r + 1'b1) == total);
    sts.out_free   = !out_valid_r || out_tready;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_char_r;
  assign out_tlast  = out_last_r;

  // Leading zeros are a part of the stored bytes.
  a_zero_le_count: assert property (@(posedge clk) disable iff (!rst_n)
    zero_cnt_r <= byte_cnt_r)
    else $error("leading zero count exceeds byte count");

  // The byte count saturates at the store depth.
  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    byte_cnt_r <= CW'(MAX_BYTES))
    else $error("byte count beyond store depth");

  // A pass only touches stored bytes, with a remainder below the radix.
  a_pass_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.pass_step |-> (idx_r < byte_cnt_r) && (rem_r < DIGIT_W'(RADIX)))
    else $error("division step out of range");

  // The final character returns the string state to its idle values.
  a_finish: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit_load && sts.emit_last |=> byte_cnt_r == '0 && zero_cnt_r == '0 && in_zero_r)
    else $error("string state not cleared after final character");

endmodule

### design/b58_ctrl.sv
// Controller: sequences byte intake, long-division passes and character output.
module b58_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  input  logic              in_tlast,
  output logic              in_tready,
  input  b58_pkg::b58_sts_t sts,
  output b58_pkg::b58_cmd_t cmd
);
  import b58_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INIT,
    S_CHECK,
    S_PASS,
    S_DIGIT,
    S_EMIT_RD,
    S_EMIT_LD
  } state_t;

  state_t state_r;
  state_t state_nxt;

  // Command decode and next state.
  always_comb begin
    cmd       = '0;
    in_tready = 1'b0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        cmd.store = in_tvalid;
        if (in_tvalid && in_tlast) begin
          state_nxt = S_INIT;
        end
      end
      S_INIT: begin
        cmd.init  = 1'b1;
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        if (sts.start_lt_n) begin
          cmd.pass_begin = 1'b1;
          state_nxt      = S_PASS;
        end else begin
          cmd.emit_begin = 1'b1;
          state_nxt      = S_EMIT_RD;
        end
      end
      S_PASS: begin
        cmd.pass_step = 1'b1;
        if (sts.pass_last) begin
          state_nxt = S_DIGIT;
        end
      end
      S_DIGIT: begin
        cmd.digit_wr = 1'b1;
        state_nxt    = S_CHECK;
      end
      S_EMIT_RD: begin
        state_nxt = S_EMIT_LD;
      end
      S_EMIT_LD: begin
        if (sts.out_free) begin
          cmd.emit_load = 1'b1;
          state_nxt     = sts.emit_last ? S_IDLE : S_EMIT_RD;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

### design/base58_encoder.sv
// Base58 encoder top level: byte stream in, Bitcoin-alphabet characters out.
// In idle the block takes every input byte. After the final byte, each division pass runs a
// check, a step per stored byte from the first nonzero byte and a digit write; each character
// is then read from the digit store and loaded into the output register once that is free.
// Throughput is one string at a time, set by the single shared division step.
// Reset (rst_n low, synchronous) clears the counters and control state; stores are not cleared.
module base58_encoder #(
  parameter int MAX_BYTES = 32,
  parameter int MAX_CHARS = 44
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] data_byte
  input  logic       in_tlast,
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] out_char
  output logic       out_tlast
);
  import b58_pkg::*;

  b58_cmd_t cmd;
  b58_sts_t sts;

  b58_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tlast  (in_tlast),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  b58_dp #(.MAX_BYTES(MAX_BYTES), .MAX_CHARS(MAX_CHARS)) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_data    (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

### sim/base58_encoder_tb.sv
// Self-checking testbench for the base58 encoder: directed and random byte strings.
`timescale 1ns / 1ps

module base58_encoder_tb;

  localparam int MAX_BYTES  = 32;
  localparam int MAX_CHARS  = 44;
  localparam int DIGIT_CAP  = 64;
  localparam int STALL_MAX  = 20000;
  localparam int DRAIN_WAIT = 2000;

  typedef logic [7:0] byte_q_t[$];

  // One expected output character.
  typedef struct {
    logic [7:0] ch;
    logic       last;
  } b58_char_t;

  logic       clk;
  logic       rst_n;
  logic       in_tvalid;
  logic       in_tready;
  logic [7:0] in_tdata;   // [7:0] data_byte
  logic       in_tlast;
  logic       out_tvalid;
  logic       out_tready;
  logic [7:0] out_tdata;  // [7:0] out_char
  logic       out_tlast;

  // Shadow copy of the encoder state.
  logic [7:0] held_bytes[MAX_BYTES];
  int         held_count = 0;
  int         zero_lead_count = 0;
  logic       in_zero_run = 1'b1;

  b58_char_t  pending_chars[$];

  string      b58_alphabet = "123456789ABCDEFGHJKLMNPQRSTUVWXYZabcdefghijkmnopqrstuvwxyz";

  int         tx_idle_pct;
  int         rx_idle_pct;
  int         mismatch_count = 0;
  int         strings_sent = 0;
  int         bytes_sent = 0;
  int         chars_checked = 0;
  int         stall_cycles = 0;

  base58_encoder #(
    .MAX_BYTES(MAX_BYTES),
    .MAX_CHARS(MAX_CHARS)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

  // Free-running clock.
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Long division of the held bytes by 58; queues the characters the block should emit.
  function automatic void encode_held_bytes();
    int work[MAX_BYTES];
    int digits[DIGIT_CAP];
    int n;
    int start;
    int ndig;
    int rem;
    int t;
    int total;
    b58_char_t c;
    n = (held_count > MAX_BYTES) ? MAX_BYTES : held_count;
    for (int i = 0; i < MAX_BYTES; i++) begin
      work[i] = (i < n) ? int'(held_bytes[i]) : 0;
    end
    start = zero_lead_count;
    ndig = 0;
    while (start < n && ndig < DIGIT_CAP) begin
      rem = 0;
      for (int i = start; i < n; i++) begin
        t = rem * 256 + work[i];
        work[i] = t / 58;
        rem = t % 58;
      end
      digits[ndig] = rem;
      ndig++;
      while (start < n && work[start] == 0) begin
        start++;
      end
    end
    total = zero_lead_count + ndig;
    if (total > MAX_CHARS) begin
      total = MAX_CHARS;
    end
    for (int k = 0; k < total; k++) begin
      if (k < zero_lead_count) begin
        c.ch = "1";
      end else begin
        c.ch = b58_alphabet[digits[ndig - 1 - (k - zero_lead_count)]];
      end
      c.last = (k + 1 == total);
      pending_chars.push_back(c);
    end
  endfunction

  // Track every accepted input beat and predict on the final byte of a string.
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) begin
      bytes_sent++;
      if (held_count < MAX_BYTES) begin
        held_bytes[held_count] = in_tdata;
        held_count++;
        if (in_zero_run && in_tdata == 8'h00) begin
          zero_lead_count++;
        end else begin
          in_zero_run = 1'b0;
        end
      end
      if (in_tlast) begin
        encode_held_bytes();
        strings_sent++;
        held_count = 0;
        zero_lead_count = 0;
        in_zero_run = 1'b1;
      end
    end
  end

  // Compare each accepted output beat with the oldest expected character.
  always @(posedge clk) begin
    b58_char_t want;
    if (rst_n && out_tvalid && out_tready) begin
      chars_checked++;
      if (pending_chars.size() == 0) begin
        if (mismatch_count < 10) begin
          $display("ERROR: unexpected character 0x%02h last=%0b", out_tdata, out_tlast);
        end
        mismatch_count++;
      end else begin
        want = pending_chars.pop_front();
        if (out_tdata !== want.ch || out_tlast !== want.last) begin
          if (mismatch_count < 10) begin
            $display("ERROR: char exp 0x%02h got 0x%02h, last exp %0b got %0b",
                     want.ch, out_tdata, want.last, out_tlast);
          end
          mismatch_count++;
        end
      end
    end
  end

  // Receiver side: ready drops at random per the current idle rate.
  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      out_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  // Watchdog on cycles without any beat on either side.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_MAX) begin
        $display("base58_encoder: mismatch");
        $finish;
      end
    end
  end

  // Send one byte; valid stays high into the next call unless that call idles.
  task automatic send_byte(input logic [7:0] b, input logic fin);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= fin;
    do begin
      @(posedge clk);
    end while (!in_tready);
    @(negedge clk);
  endtask

  task automatic send_string(input byte_q_t s);
    for (int i = 0; i < s.size(); i++) begin
      send_byte(s[i], i == s.size() - 1);
    end
  endtask

  // Single-byte strings: zero, the smallest and largest one-digit values, the smallest two-digit value, and 0xFF.
  task automatic test_single_bytes();
    send_string('{8'h00});
    send_string('{8'h01});
    send_string('{8'h39});
    send_string('{8'h3A});
    send_string('{8'hFF});
  endtask

  // Leading zero bytes, including an all-zero string and a zero after the data starts.
  task automatic test_leading_zeros();
    send_string('{8'h00, 8'h00, 8'h00});
    send_string('{8'h00, 8'h00, 8'h01, 8'h00});
    send_string('{8'h00, 8'hAA, 8'h55});
  endtask

  // Largest number the store holds, with extra bytes past the full store.
  task automatic test_store_full();
    byte_q_t s;
    for (int i = 0; i < MAX_BYTES + 2; i++) begin
      s.push_back(8'hFF);
    end
    send_string(s);
  endtask

  // Random strings: mostly short, some filling or overrunning the store.
  task automatic test_random_strings(input int item_goal);
    byte_q_t s;
    int sent;
    int len;
    int pick;
    int style;
    int nz;
    sent = 0;
    while (sent < item_goal) begin
      pick = $urandom_range(0, 99);
      if (pick < 75) begin
        len = $urandom_range(1, 4);
      end else if (pick < 90) begin
        len = $urandom_range(5, 16);
      end else if (pick < 97) begin
        len = $urandom_range(17, MAX_BYTES);
      end else begin
        len = $urandom_range(MAX_BYTES + 1, MAX_BYTES + 4);
      end
      style = $urandom_range(0, 9);
      nz = (style >= 2 && style <= 3) ? $urandom_range(1, len) : 0;
      s.delete();
      for (int i = 0; i < len; i++) begin
        if (style == 0 || i < nz) begin
          s.push_back(8'h00);
        end else if (style == 1) begin
          s.push_back(8'hFF);
        end else begin
          s.push_back(8'($urandom_range(0, 255)));
        end
      end
      send_string(s);
      sent += len;
    end
  endtask

  // Main sequence.
  initial begin
    rst_n           = 1'b0;
    in_tvalid       = 1'b0;
    in_tdata        = 8'h00;
    in_tlast        = 1'b0;
    tx_idle_pct     = 23;
    rx_idle_pct     = 54;

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_single_bytes();
    test_leading_zeros();
    test_store_full();
    test_random_strings(50);

    tx_idle_pct = 54;
    rx_idle_pct = 23;
    test_random_strings(50);

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    test_random_strings(50);

    in_tvalid <= 1'b0;

    // Drain the outstanding characters, then watch for stray ones.
    while (pending_chars.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("Encoded %0d strings from %0d input bytes; %0d characters checked.",
             strings_sent, bytes_sent, chars_checked);
    $display("Covered zero prefixes, full and overrun stores, and three idle patterns.");
    if (mismatch_count == 0 && pending_chars.size() == 0) begin
      $display("base58_encoder: match");
    end else begin
      $display("base58_encoder: mismatch");
    end
    $finish;
  end

endmodule
